// ===== hdl/htbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htbd_pkg
// Shared types and constants of the Huffman tree bit decoder.
// ----------------------------------------------------------------------------
package htbd_pkg;

	localparam int NODE_COUNT   = 512;
	localparam int MAX_CODE_LEN = 32;
	localparam int MAX_DIM      = 4096;

	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int NF_W       = $clog2(NODE_COUNT + 1);
	localparam int CODE_W     = 32;
	localparam int LEN_W      = 6;
	localparam int CODE_IDX_W = $clog2(CODE_W);
	localparam int VAL_W      = 8;
	localparam int DIM_W      = 13;
	localparam int POS_W      = 12;
	localparam int CFG_IDX_W  = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_PIXEL  = 2'd0,
		ST_STORED = 2'd1,
		ST_FULL   = 2'd2,
		ST_BAD    = 2'd3
	} status_t;

	typedef struct packed {
		logic              leaf;
		logic [VAL_W-1:0]  val;
		logic [NODE_W-1:0] left;
		logic [NODE_W-1:0] right;
	} node_t;

	typedef struct packed {
		status_t          st;
		logic [VAL_W-1:0] val;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             done;
	} res_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_RD,
		OP_P1_STEP,
		OP_RESTART,
		OP_P2_STEP,
		OP_FRESH,
		OP_RD_CUR,
		OP_D_STEP,
		OP_D_LEAF
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   push;
	} cmd_t;

	typedef struct packed {
		logic in_decode;
		logic in_bad_len;
		logic img_done;
		logic child_zero;
		logic last_bit;
		logic idx_zero;
		logic full;
		logic leaf;
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/htbd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htbd_ctrl
// Sequencer for insert walks (count pass, write pass) and decode steps.
// ----------------------------------------------------------------------------
module htbd_ctrl
	import htbd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [10:0] {
		S_IDLE     = 11'b00000000001,
		S_P1_RD    = 11'b00000000010,
		S_P1_CHK   = 11'b00000000100,
		S_CHECK    = 11'b00000001000,
		S_P2_RD    = 11'b00000010000,
		S_P2_CHK   = 11'b00000100000,
		S_P2_FRESH = 11'b00001000000,
		S_D_RD     = 11'b00010000000,
		S_D_CHK    = 11'b00100000000,
		S_D_LEAF   = 11'b01000000000,
		S_EMIT     = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NOP;
		cmd.push = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					if (!sts.in_decode) begin
						state_d = sts.in_bad_len ? S_EMIT : S_P1_RD;
					end else begin
						state_d = sts.img_done ? S_IDLE : S_D_RD;
					end
				end
			end
			S_P1_RD: begin
				cmd.op  = OP_RD;
				state_d = S_P1_CHK;
			end
			S_P1_CHK: begin
				cmd.op  = OP_P1_STEP;
				state_d = (sts.child_zero || sts.last_bit) ? S_CHECK : S_P1_RD;
			end
			S_CHECK: begin
				cmd.op  = OP_RESTART;
				state_d = sts.full ? S_EMIT : S_P2_RD;
			end
			S_P2_RD: begin
				cmd.op  = OP_RD;
				state_d = S_P2_CHK;
			end
			S_P2_CHK: begin
				cmd.op = OP_P2_STEP;
				priority if (sts.idx_zero) begin
					state_d = S_EMIT;
				end else if (sts.child_zero) begin
					state_d = S_P2_FRESH;
				end else begin
					state_d = S_P2_RD;
				end
			end
			S_P2_FRESH: begin
				cmd.op = OP_FRESH;
				if (sts.idx_zero) begin
					state_d = S_EMIT;
				end
			end
			S_D_RD: begin
				cmd.op  = OP_RD_CUR;
				state_d = S_D_CHK;
			end
			S_D_CHK: begin
				cmd.op  = OP_D_STEP;
				state_d = sts.child_zero ? S_EMIT : S_D_LEAF;
			end
			S_D_LEAF: begin
				cmd.op  = OP_D_LEAF;
				state_d = sts.leaf ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/htbd_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htbd_dp
// Node table, walk registers, pixel position counters and output register.
// ----------------------------------------------------------------------------
module htbd_dp
	import htbd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 req_type,
	input  logic [CODE_W-1:0]    code_bits,
	input  logic [LEN_W-1:0]     code_length,
	input  logic [VAL_W-1:0]     symbol_value,
	input  logic                 bit_in,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [VAL_W-1:0]     pixel_value,
	output logic [POS_W-1:0]     pixel_row,
	output logic [POS_W-1:0]     pixel_col,
	output logic                 image_done
);

	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

	// node zero (root) lives in flops; entries 1.. are only read once allocated
	node_t             mem [NODE_COUNT];
	node_t             mem_q;
	node_t             root_q;
	logic              rd_root_q;

	logic [CODE_W-1:0] code_q;
	logic [LEN_W-1:0]  len_q;
	logic [VAL_W-1:0]  sym_q;
	logic              bit_q;
	logic [LEN_W-1:0]  idx_q;
	logic [LEN_W-1:0]  need_q;
	logic [NODE_W-1:0] node_q;
	logic [NODE_W-1:0] cur_q;
	logic [NF_W-1:0]   nf_q;
	logic [DIM_W-1:0]  row_q;
	logic [POS_W-1:0]  col_q;
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	res_t              res_q;
	res_t              out_q;
	logic              out_valid_q;

	node_t             rdata;
	logic              bit_sel;
	logic [NODE_W-1:0] child;
	logic [NODE_W-1:0] nf_idx;
	logic              rd_en;
	logic [NODE_W-1:0] rd_addr;
	logic              wr_en;
	logic [NODE_W-1:0] wr_addr;
	node_t             wr_data;
	node_t             new_entry;
	logic [DIM_W-1:0]  w_eff;
	logic [DIM_W-1:0]  h_eff;
	logic [DIM_W-1:0]  col_inc;
	logic [DIM_W-1:0]  row_inc;
	logic [NF_W:0]     nf_sum;
	logic              out_free;

	assign rdata   = rd_root_q ? root_q : mem_q;
	assign bit_sel = (cmd.op == OP_D_STEP) ? bit_q
	                                       : code_q[CODE_IDX_W'(idx_q - 1'b1)];
	assign child   = bit_sel ? rdata.right : rdata.left;
	assign nf_idx  = nf_q[NODE_W-1:0];

	assign w_eff   = (width_q == '0) ? DIM_W'(1) : ((width_q > DIM_MAX) ? DIM_MAX : width_q);
	assign h_eff   = (height_q > DIM_MAX) ? DIM_MAX : height_q;
	assign col_inc = {1'b0, col_q} + 1'b1;
	assign row_inc = row_q + 1'b1;
	assign nf_sum  = {1'b0, nf_q} + (NF_W + 1)'(need_q);

	assign out_free = !out_valid_q || out_ready;

	assign sts.in_decode  = req_type;
	assign sts.in_bad_len = (code_length == '0) || (code_length > LEN_W'(MAX_CODE_LEN));
	assign sts.img_done   = (row_q >= h_eff);
	assign sts.child_zero = (child == '0);
	assign sts.last_bit   = (idx_q == LEN_W'(1));
	assign sts.idx_zero   = (idx_q == '0);
	assign sts.full       = (nf_sum > (NF_W + 1)'(NODE_COUNT));
	assign sts.leaf       = rdata.leaf;
	assign sts.out_free   = out_free;

	// read port select and insert-pass writes
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = node_q;
		wr_en     = 1'b0;
		wr_addr   = node_q;
		new_entry = '0;
		wr_data   = rdata;
		unique case (cmd.op)
			OP_RD: begin
				rd_en = 1'b1;
			end
			OP_RD_CUR: begin
				rd_en   = 1'b1;
				rd_addr = cur_q;
			end
			OP_D_STEP: begin
				rd_en   = !sts.child_zero;
				rd_addr = child;
			end
			OP_P2_STEP: begin
				if (idx_q == '0) begin
					wr_en        = 1'b1;
					wr_data.leaf = 1'b1;
					wr_data.val  = sym_q;
				end else if (child == '0) begin
					wr_en = 1'b1;
					if (bit_sel) begin
						wr_data.right = nf_idx;
					end else begin
						wr_data.left = nf_idx;
					end
				end
			end
			OP_FRESH: begin
				// freshly allocated node: its content is known to be empty
				wr_en = 1'b1;
				if (idx_q == '0) begin
					new_entry.leaf = 1'b1;
					new_entry.val  = sym_q;
				end else if (bit_sel) begin
					new_entry.right = nf_idx;
				end else begin
					new_entry.left = nf_idx;
				end
				wr_data = new_entry;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr != '0)) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_q <= mem[rd_addr];
		end
	end

	// control state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q      <= '0;
			rd_root_q   <= 1'b0;
			cur_q       <= '0;
			nf_q        <= NF_W'(1);
			row_q       <= '0;
			col_q       <= '0;
			width_q     <= DIM_W'(1);
			height_q    <= DIM_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_root_q <= (rd_addr == '0);
			end
			if (wr_en && (wr_addr == '0)) begin
				root_q <= wr_data;
			end
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_WIDTH:  width_q  <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (((cmd.op == OP_P2_STEP) && (idx_q != '0) && (child == '0)) ||
			    ((cmd.op == OP_FRESH) && (idx_q != '0))) begin
				nf_q <= nf_q + 1'b1;
			end
			if ((cmd.op == OP_D_STEP) && (child == '0)) begin
				cur_q <= '0;
			end
			if (cmd.op == OP_D_LEAF) begin
				if (!rdata.leaf) begin
					cur_q <= node_q;
				end else begin
					cur_q <= '0;
					if (col_inc >= w_eff) begin
						col_q <= '0;
						row_q <= row_inc;
					end else begin
						col_q <= col_inc[POS_W-1:0];
					end
				end
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk and result payload
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				code_q <= code_bits;
				len_q  <= code_length;
				sym_q  <= symbol_value;
				bit_q  <= bit_in;
				idx_q  <= code_length;
				need_q <= '0;
				node_q <= '0;
				res_q  <= '{st: ST_BAD, val: '0, row: '0, col: '0, done: 1'b0};
			end
			OP_P1_STEP: begin
				if (child == '0) begin
					need_q <= idx_q;
				end else begin
					node_q <= child;
					idx_q  <= idx_q - 1'b1;
				end
			end
			OP_RESTART: begin
				node_q <= '0;
				idx_q  <= len_q;
				res_q  <= '{st: ST_FULL, val: '0, row: '0, col: '0, done: 1'b0};
			end
			OP_P2_STEP: begin
				if (idx_q == '0) begin
					res_q <= '{st: ST_STORED, val: '0, row: '0, col: '0, done: 1'b0};
				end else begin
					node_q <= (child == '0) ? nf_idx : child;
					idx_q  <= idx_q - 1'b1;
				end
			end
			OP_FRESH: begin
				if (idx_q == '0) begin
					res_q <= '{st: ST_STORED, val: '0, row: '0, col: '0, done: 1'b0};
				end else begin
					node_q <= nf_idx;
					idx_q  <= idx_q - 1'b1;
				end
			end
			OP_D_STEP: begin
				node_q <= child;
			end
			OP_D_LEAF: begin
				res_q.st   <= ST_PIXEL;
				res_q.val  <= rdata.val;
				res_q.row  <= row_q[POS_W-1:0];
				res_q.col  <= col_q;
				res_q.done <= (col_inc >= w_eff) && (row_inc >= h_eff);
			end
			default: begin
			end
		endcase
		if (cmd.push) begin
			out_q <= res_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.st;
	assign pixel_value = out_q.val;
	assign pixel_row   = out_q.row;
	assign pixel_col   = out_q.col;
	assign image_done  = out_q.done;

endmodule

// ===== hdl/huffman_tree_bit_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder
// Bit-serial Huffman decoder walking a code tree held in a 512-node table.
// ----------------------------------------------------------------------------
// Decode beat: node read, child read and leaf check to the result register,
//   then the emit stage; the table read is registered.
// Insert beat: for an L-bit code, a count pass, then a write pass.
// One item in flight; a finished result waits in the output register.
// Reset (async, active low) empties the tree at once through the free-node
//   count; no clearing pass. Width and height reset to 1.
module huffman_tree_bit_decoder
	import htbd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 req_type,
	input  logic [CODE_W-1:0]    code_bits,
	input  logic [LEN_W-1:0]     code_length,
	input  logic [VAL_W-1:0]     symbol_value,
	input  logic                 bit_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [VAL_W-1:0]     pixel_value,
	output logic [POS_W-1:0]     pixel_row,
	output logic [POS_W-1:0]     pixel_col,
	output logic                 image_done,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	htbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	htbd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.code_bits    (code_bits),
		.code_length  (code_length),
		.symbol_value (symbol_value),
		.bit_in       (bit_in),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.pixel_value  (pixel_value),
		.pixel_row    (pixel_row),
		.pixel_col    (pixel_col),
		.image_done   (image_done)
	);

endmodule
